### sv/scanline_span_merge_macros.svh
// Assertion helpers for the span merge controller
`ifndef SCANLINE_SPAN_MERGE_MACROS_SVH
`define SCANLINE_SPAN_MERGE_MACROS_SVH

// fire implies cond in the same cycle
`define SSM_ASSERT_NOW(lbl, fire, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (fire) |-> (cond)) \
        else $error(msg);

// fire implies cond in the following cycle
`define SSM_ASSERT_NEXT(lbl, fire, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (fire) |=> (cond)) \
        else $error(msg);

`endif

### sv/ssm_pkg.sv
package ssm_pkg;

    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int COL_W   = 12;
    localparam int CNT_W   = 7;
    localparam int ERR_W   = 3;
    localparam int POS_W   = 11;
    localparam int SUM_W   = 12;
    localparam int PROD_W  = 23;
    localparam int STEP_W  = 5;

    localparam logic [POS_W-1:0]  POS_LIMIT     = 11'd2047;
    localparam logic [CNT_W-1:0]  MAX_SEG_RESET = 7'd32;
    localparam logic [STEP_W-1:0] DIV_STEPS     = 5'd23;

    localparam logic [ERR_W-1:0] ST_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ST_BEFORE     = 3'd1;
    localparam logic [ERR_W-1:0] ST_CLIP_START = 3'd2;
    localparam logic [ERR_W-1:0] ST_INSERT     = 3'd3;
    localparam logic [ERR_W-1:0] ST_CLIP_END   = 3'd4;
    localparam logic [ERR_W-1:0] ST_AFTER      = 3'd5;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_BEFORE = 4'b0010,
        PH_COVER  = 4'b0100,
        PH_AFTER  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        SLOT_PASS = 3'd0,
        SLOT_CLIP = 3'd1,
        SLOT_SPAN = 3'd2,
        SLOT_REST = 3'd3,
        SLOT_TAIL = 3'd4
    } slot_t;

    typedef struct packed {
        logic       load_span;
        logic       load_seg;
        logic       set_err;
        logic       lerp_start;
        logic [1:0] ch;
        logic       clip_store;
        logic       capture;
        logic       out_pend;
        logic       out_pend_last;
        logic       out_ovf;
        logic       finish;
        slot_t      slot;
    } cmd_t;

    typedef struct packed {
        logic phase_idle;
        logic slot_en;
        logic slot_clip;
        logic err_set;
        logic count_full;
        logic pend_valid;
        logic out_free;
        logic seg_last;
        logic lerp_busy;
        logic lerp_done;
    } sts_t;

endpackage

### sv/scanline_span_merge.sv
// Scanline span merge.
// Input channel (in_valid/in_stall): kind 0 loads a new span and opens a merge;
// kind 1 is an old segment of the scanline, list_end on the last one. Output
// channel (out_valid/out_stall): up to three result words per old segment, plus
// an overflow word with out_last at list end if the limit was hit.
// cfg_valid/cfg_ready writes max_out_segments; cfg_ready is always high.
// Each clipped end of an old segment needs three interpolations, one per
// colour channel, run one after another on the one shared shift-subtract
// divider.
// Reset clears the merge state and sets the limit to 32; segments are ignored
// until a span has been loaded.
// A stalled output holds its word; the block works on until its one pending word
// must be sent, then waits, and takes no new item until it has finished.
module scanline_span_merge
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [ssm_pkg::START_W-1:0]     start_req,
    input  logic [ssm_pkg::LEN_W-1:0]       length,
    input  logic [ssm_pkg::COL_W-1:0]       red_begin,
    input  logic [ssm_pkg::COL_W-1:0]       green_begin,
    input  logic [ssm_pkg::COL_W-1:0]       blue_begin,
    input  logic [ssm_pkg::COL_W-1:0]       red_end,
    input  logic [ssm_pkg::COL_W-1:0]       green_end,
    input  logic [ssm_pkg::COL_W-1:0]       blue_end,
    input  logic                            list_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssm_pkg::CNT_W-1:0]       max_out_segments,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssm_pkg::LEN_W-1:0]       out_length,
    output logic [ssm_pkg::COL_W-1:0]       out_red_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_green_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_blue_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_red_end,
    output logic [ssm_pkg::COL_W-1:0]       out_green_end,
    output logic [ssm_pkg::COL_W-1:0]       out_blue_end,
    output logic [ssm_pkg::ERR_W-1:0]       status,
    output logic                            out_last
);

    ssm_pkg::cmd_t cmd;
    ssm_pkg::sts_t sts;

    ssm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssm_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .start_req        (start_req),
        .length           (length),
        .red_begin        (red_begin),
        .green_begin      (green_begin),
        .blue_begin       (blue_begin),
        .red_end          (red_end),
        .green_end        (green_end),
        .blue_end         (blue_end),
        .list_end         (list_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .max_out_segments (max_out_segments),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_length       (out_length),
        .out_red_begin    (out_red_begin),
        .out_green_begin  (out_green_begin),
        .out_blue_begin   (out_blue_begin),
        .out_red_end      (out_red_end),
        .out_green_end    (out_green_end),
        .out_blue_end     (out_blue_end),
        .status           (status),
        .out_last         (out_last)
    );

endmodule

### sv/ssm_lerp.sv
module ssm_lerp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssm_pkg::COL_W-1:0]     a,
    input  logic [ssm_pkg::COL_W-1:0]     b,
    input  logic [ssm_pkg::LEN_W-1:0]     off,
    input  logic [ssm_pkg::LEN_W-1:0]     len,
    output logic                          busy,
    output logic                          done,
    output logic [ssm_pkg::COL_W-1:0]     result
);

    logic                           busy_reg, busy_next;
    logic [ssm_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [ssm_pkg::PROD_W-1:0]     quo_reg, quo_next;
    logic [ssm_pkg::LEN_W-1:0]      rem_reg, rem_next;
    logic [ssm_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [ssm_pkg::COL_W-1:0]      a_reg, a_next;
    logic                           neg_reg, neg_next;

    logic [ssm_pkg::COL_W:0]        diff;
    logic [ssm_pkg::COL_W-1:0]      mag;
    logic [ssm_pkg::LEN_W:0]        rem_t;
    logic                           ge;
    logic [ssm_pkg::COL_W-1:0]      q;

    always_comb
    begin
        diff = {1'b0, b} - {1'b0, a};
        mag  = diff[ssm_pkg::COL_W] ? ssm_pkg::COL_W'(-diff) : diff[ssm_pkg::COL_W-1:0];
        rem_t = {rem_reg, quo_reg[ssm_pkg::PROD_W-1]};
        ge    = rem_t >= {1'b0, len_reg};
        done  = busy_reg && (cnt_reg == '0);
        q     = quo_reg[ssm_pkg::COL_W-1:0];
        result = neg_reg ? (a_reg - q) : (a_reg + q);

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        a_next    = a_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ssm_pkg::DIV_STEPS;
            quo_next  = {{(ssm_pkg::PROD_W-ssm_pkg::COL_W){1'b0}}, mag}
                      * {{(ssm_pkg::PROD_W-ssm_pkg::LEN_W){1'b0}}, off};
            rem_next  = '0;
            len_next  = len;
            a_next    = a;
            neg_next  = diff[ssm_pkg::COL_W];
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? ssm_pkg::LEN_W'(rem_t - {1'b0, len_reg})
                          : rem_t[ssm_pkg::LEN_W-1:0];
            quo_next = {quo_reg[ssm_pkg::PROD_W-2:0], ge};
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        len_reg <= len_next;
        a_reg   <= a_next;
        neg_reg <= neg_next;
    end

endmodule

### sv/ssm_dp.sv
module ssm_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssm_pkg::cmd_t                   cmd,
    output ssm_pkg::sts_t                   sts,
    input  logic [ssm_pkg::START_W-1:0]     start_req,
    input  logic [ssm_pkg::LEN_W-1:0]       length,
    input  logic [ssm_pkg::COL_W-1:0]       red_begin,
    input  logic [ssm_pkg::COL_W-1:0]       green_begin,
    input  logic [ssm_pkg::COL_W-1:0]       blue_begin,
    input  logic [ssm_pkg::COL_W-1:0]       red_end,
    input  logic [ssm_pkg::COL_W-1:0]       green_end,
    input  logic [ssm_pkg::COL_W-1:0]       blue_end,
    input  logic                            list_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssm_pkg::CNT_W-1:0]       max_out_segments,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssm_pkg::LEN_W-1:0]       out_length,
    output logic [ssm_pkg::COL_W-1:0]       out_red_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_green_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_blue_begin,
    output logic [ssm_pkg::COL_W-1:0]       out_red_end,
    output logic [ssm_pkg::COL_W-1:0]       out_green_end,
    output logic [ssm_pkg::COL_W-1:0]       out_blue_end,
    output logic [ssm_pkg::ERR_W-1:0]       status,
    output logic                            out_last
);

    logic [ssm_pkg::CNT_W-1:0]      max_reg;
    logic [ssm_pkg::START_W-1:0]    span_start_reg;
    logic [ssm_pkg::LEN_W-1:0]      span_len_reg;
    logic [ssm_pkg::COL_W-1:0]      span_col_reg [6];
    logic [ssm_pkg::POS_W-1:0]      pos_reg;
    logic [ssm_pkg::CNT_W-1:0]      count_reg;
    ssm_pkg::phase_t                phase_reg, phase_next;
    logic [ssm_pkg::ERR_W-1:0]      err_reg;
    logic                           pend_valid_reg;
    logic                           out_valid_reg;

    logic [ssm_pkg::LEN_W-1:0]      seg_len_reg;
    logic [ssm_pkg::COL_W-1:0]      seg_col_reg [6];
    logic                           seg_last_reg;
    logic [ssm_pkg::COL_W-1:0]      clip_reg [3];
    logic [ssm_pkg::LEN_W-1:0]      pend_len_reg;
    logic [ssm_pkg::COL_W-1:0]      pend_col_reg [6];
    logic [ssm_pkg::LEN_W-1:0]      out_len_reg;
    logic [ssm_pkg::COL_W-1:0]      out_col_reg [6];
    logic [ssm_pkg::ERR_W-1:0]      out_status_reg;
    logic                           out_last_reg;

    logic [ssm_pkg::COL_W-1:0]      in_col [6];
    logic [ssm_pkg::SUM_W-1:0]      pe1, se1, off_end, off_start;
    logic                           a_cond, p_lt_s, c_cond, p_le_se;
    logic                           ph1, ph2, ph3, ends;
    logic [ssm_pkg::POS_W-1:0]      pos_sat;
    logic                           slot_en, slot_clip;
    logic [ssm_pkg::ERR_W-1:0]      cand_stage;
    logic [ssm_pkg::LEN_W-1:0]      cand_len;
    logic [ssm_pkg::COL_W-1:0]      cand_col [6];
    logic [ssm_pkg::LEN_W-1:0]      lerp_off;
    logic                           lerp_busy, lerp_done;
    logic [ssm_pkg::COL_W-1:0]      lerp_res;
    logic                           out_free;

    assign in_col[0] = red_begin;
    assign in_col[1] = green_begin;
    assign in_col[2] = blue_begin;
    assign in_col[3] = red_end;
    assign in_col[4] = green_end;
    assign in_col[5] = blue_end;

    // positions kept off by one so that nothing goes negative
    always_comb
    begin
        pe1       = {1'b0, pos_reg} + {1'b0, seg_len_reg};
        se1       = {2'b0, span_start_reg} + {1'b0, span_len_reg};
        off_end   = se1 - {1'b0, pos_reg};
        off_start = {2'b0, span_start_reg} - {1'b0, pos_reg};
        a_cond    = (span_len_reg == '0) || (pe1 <= {2'b0, span_start_reg});
        p_lt_s    = {1'b0, pos_reg} < {2'b0, span_start_reg};
        p_le_se   = {1'b0, pos_reg} < se1;
        c_cond    = !(p_le_se && (pe1 <= se1));
        ph1       = phase_reg == ssm_pkg::PH_BEFORE;
        ph3       = phase_reg == ssm_pkg::PH_AFTER;
        ph2       = (phase_reg == ssm_pkg::PH_COVER) || (ph1 && !a_cond);
        ends      = ph2 && c_cond;
        pos_sat   = pe1[ssm_pkg::SUM_W-1] ? ssm_pkg::POS_LIMIT : pe1[ssm_pkg::POS_W-1:0];

        if (seg_last_reg)
            phase_next = ssm_pkg::PH_WAIT;
        else if (ends)
            phase_next = ssm_pkg::PH_AFTER;
        else if (ph2)
            phase_next = ssm_pkg::PH_COVER;
        else
            phase_next = phase_reg;
    end

    always_comb
    begin
        slot_en    = 1'b0;
        slot_clip  = 1'b0;
        cand_stage = ssm_pkg::ST_OK;
        cand_len   = seg_len_reg;
        cand_col   = seg_col_reg;
        case (cmd.slot)
            ssm_pkg::SLOT_PASS:
            begin
                slot_en    = ph1 && a_cond;
                cand_stage = ssm_pkg::ST_BEFORE;
            end
            ssm_pkg::SLOT_CLIP:
            begin
                slot_en     = ph1 && !a_cond && p_lt_s;
                slot_clip   = 1'b1;
                cand_stage  = ssm_pkg::ST_CLIP_START;
                cand_len    = off_start[ssm_pkg::LEN_W-1:0];
                cand_col[3] = clip_reg[0];
                cand_col[4] = clip_reg[1];
                cand_col[5] = clip_reg[2];
            end
            ssm_pkg::SLOT_SPAN:
            begin
                slot_en    = ends;
                cand_stage = ssm_pkg::ST_INSERT;
                cand_len   = span_len_reg;
                cand_col   = span_col_reg;
            end
            ssm_pkg::SLOT_REST:
            begin
                slot_en = ends || ph3;
                if (ends && p_le_se)
                begin
                    slot_clip   = 1'b1;
                    cand_stage  = ssm_pkg::ST_CLIP_END;
                    cand_len    = seg_len_reg - off_end[ssm_pkg::LEN_W-1:0];
                    cand_col[0] = clip_reg[0];
                    cand_col[1] = clip_reg[1];
                    cand_col[2] = clip_reg[2];
                end
                else
                begin
                    cand_stage = ssm_pkg::ST_AFTER;
                end
            end
            ssm_pkg::SLOT_TAIL:
            begin
                slot_en    = seg_last_reg && ((ph2 && !c_cond)
                             || (ph1 && a_cond && (span_len_reg != '0)));
                cand_stage = ssm_pkg::ST_INSERT;
                cand_len   = span_len_reg;
                cand_col   = span_col_reg;
            end
            default:
            begin
                slot_en = 1'b0;
            end
        endcase
        lerp_off = (cmd.slot == ssm_pkg::SLOT_CLIP) ? off_start[ssm_pkg::LEN_W-1:0]
                                                    : off_end[ssm_pkg::LEN_W-1:0];
    end

    ssm_lerp u_lerp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.lerp_start),
        .a      (seg_col_reg[{1'b0, cmd.ch}]),
        .b      (seg_col_reg[3'd3 + {1'b0, cmd.ch}]),
        .off    (lerp_off),
        .len    (seg_len_reg),
        .busy   (lerp_busy),
        .done   (lerp_done),
        .result (lerp_res)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        sts.phase_idle = phase_reg == ssm_pkg::PH_WAIT;
        sts.slot_en    = slot_en;
        sts.slot_clip  = slot_clip;
        sts.err_set    = err_reg != ssm_pkg::ST_OK;
        sts.count_full = count_reg >= max_reg;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
        sts.seg_last   = seg_last_reg;
        sts.lerp_busy  = lerp_busy;
        sts.lerp_done  = lerp_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg        <= ssm_pkg::MAX_SEG_RESET;
            span_start_reg <= '0;
            span_len_reg   <= '0;
            span_col_reg   <= '{default: '0};
            pos_reg        <= '0;
            count_reg      <= '0;
            phase_reg      <= ssm_pkg::PH_WAIT;
            err_reg        <= ssm_pkg::ST_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_reg <= max_out_segments;
            if (cmd.load_span)
            begin
                span_start_reg <= start_req;
                span_len_reg   <= length;
                span_col_reg   <= in_col;
                pos_reg        <= '0;
                count_reg      <= '0;
                err_reg        <= ssm_pkg::ST_OK;
                phase_reg      <= ssm_pkg::PH_BEFORE;
            end
            if (cmd.set_err)
                err_reg <= cand_stage;
            if (cmd.capture)
                count_reg <= count_reg + 1'b1;
            if (cmd.finish)
            begin
                phase_reg <= phase_next;
                if (seg_last_reg)
                begin
                    pos_reg   <= '0;
                    count_reg <= '0;
                    err_reg   <= ssm_pkg::ST_OK;
                end
                else
                begin
                    pos_reg <= pos_sat;
                end
            end
            if (cmd.capture)
                pend_valid_reg <= 1'b1;
            else if (cmd.out_pend)
                pend_valid_reg <= 1'b0;
            if (cmd.out_pend || cmd.out_ovf)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seg)
        begin
            seg_len_reg  <= length;
            seg_col_reg  <= in_col;
            seg_last_reg <= list_end;
        end
        if (cmd.clip_store)
            clip_reg[cmd.ch] <= lerp_res;
        if (cmd.capture)
        begin
            pend_len_reg <= cand_len;
            pend_col_reg <= cand_col;
        end
        if (cmd.out_pend)
        begin
            out_len_reg    <= pend_len_reg;
            out_col_reg    <= pend_col_reg;
            out_status_reg <= ssm_pkg::ST_OK;
            out_last_reg   <= cmd.out_pend_last;
        end
        else if (cmd.out_ovf)
        begin
            out_len_reg    <= '0;
            out_col_reg    <= '{default: '0};
            out_status_reg <= err_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_length      = out_len_reg;
    assign out_red_begin   = out_col_reg[0];
    assign out_green_begin = out_col_reg[1];
    assign out_blue_begin  = out_col_reg[2];
    assign out_red_end     = out_col_reg[3];
    assign out_green_end   = out_col_reg[4];
    assign out_blue_end    = out_col_reg[5];
    assign status          = out_status_reg;
    assign out_last        = out_last_reg;

endmodule

### sv/ssm_ctrl.sv
`include "scanline_span_merge_macros.svh"

module ssm_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            kind,
    output logic            in_stall,
    input  ssm_pkg::sts_t   sts,
    output ssm_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SLOT   = 8'b0000_0010,
        S_LSTART = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_CAPT   = 8'b0001_0000,
        S_END    = 8'b0010_0000,
        S_OVF    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    ssm_pkg::slot_t slot_reg, slot_next, slot_inc;
    logic [1:0]     ch_reg, ch_next;
    logic           adv;

    always_comb
    begin
        case (slot_reg)
            ssm_pkg::SLOT_PASS: slot_inc = ssm_pkg::SLOT_CLIP;
            ssm_pkg::SLOT_CLIP: slot_inc = ssm_pkg::SLOT_SPAN;
            ssm_pkg::SLOT_SPAN: slot_inc = ssm_pkg::SLOT_REST;
            ssm_pkg::SLOT_REST: slot_inc = ssm_pkg::SLOT_TAIL;
            default:            slot_inc = ssm_pkg::SLOT_TAIL;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.slot   = slot_reg;
        cmd.ch     = ch_reg;
        in_stall   = 1'b1;
        state_next = state_reg;
        slot_next  = slot_reg;
        ch_next    = ch_reg;
        adv        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!kind)
                    begin
                        cmd.load_span = 1'b1;
                    end
                    else
                    begin
                        cmd.load_seg = 1'b1;
                        if (!sts.phase_idle)
                        begin
                            slot_next  = ssm_pkg::SLOT_PASS;
                            state_next = S_SLOT;
                        end
                    end
                end
            end
            S_SLOT:
            begin
                if (!sts.slot_en || sts.err_set)
                begin
                    adv = 1'b1;
                end
                else if (sts.count_full)
                begin
                    cmd.set_err = 1'b1;
                    adv         = 1'b1;
                end
                else if (sts.slot_clip)
                begin
                    ch_next    = 2'd0;
                    state_next = S_LSTART;
                end
                else
                begin
                    state_next = S_CAPT;
                end
            end
            S_LSTART:
            begin
                cmd.lerp_start = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (sts.lerp_done)
                begin
                    cmd.clip_store = 1'b1;
                    if (ch_reg == 2'd2)
                    begin
                        state_next = S_CAPT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_LSTART;
                    end
                end
            end
            S_CAPT:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.out_pend = sts.pend_valid;
                    cmd.capture  = 1'b1;
                    adv          = 1'b1;
                end
            end
            S_END:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.out_pend      = sts.pend_valid;
                    cmd.out_pend_last = sts.seg_last && !sts.err_set;
                    state_next        = (sts.seg_last && sts.err_set) ? S_OVF : S_FIN;
                end
            end
            S_OVF:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ovf = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (adv)
        begin
            if (slot_reg == ssm_pkg::SLOT_TAIL)
                state_next = S_END;
            else
            begin
                slot_next  = slot_inc;
                state_next = S_SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= ssm_pkg::SLOT_PASS;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            ch_reg    <= ch_next;
        end
    end

    `SSM_ASSERT_NOW(a_out_load_free, cmd.out_pend || cmd.out_ovf, sts.out_free, "output word overwritten while held")
    `SSM_ASSERT_NOW(a_lerp_idle, cmd.lerp_start, !sts.lerp_busy, "interpolator started while busy")
    `SSM_ASSERT_NOW(a_capture_room, cmd.capture, !sts.pend_valid || cmd.out_pend, "pending word lost")
    `SSM_ASSERT_NEXT(a_finish_ready, cmd.finish, !in_stall, "not ready after item finished")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit        kind;
        bit [9:0]  start;
        bit [10:0] len;
        bit [11:0] col[6];
        bit        last;
    } word_t;

    typedef struct {
        bit [10:0] len;
        bit [11:0] col[6];
        bit [2:0]  status;
        bit        last;
    } seg_t;

    class merge_scoreboard;
        seg_t            pending[$];
        int              errors;
        bit [6:0]        seg_limit;
        bit [9:0]        sp_start;
        bit [10:0]       sp_len;
        bit [11:0]       sp_col[6];
        int              pos;
        int              count;
        bit [2:0]        err;
        ssm_pkg::phase_t ph;
        int              made;

        function new();
            errors = 0;
            seg_limit = ssm_pkg::MAX_SEG_RESET;
            sp_start = 0;
            sp_len = 0;
            foreach (sp_col[i]) sp_col[i] = 0;
            pos = 0;
            count = 0;
            err = ssm_pkg::ST_OK;
            ph = ssm_pkg::PH_WAIT;
        endfunction

        function bit [11:0] interp(bit [11:0] a, bit [11:0] b, int off, int len);
            longint d;
            longint t;
            d = longint'(b) - longint'(a);
            t = (d * off) / len;
            return 12'(longint'(a) + t);
        endfunction

        function void emit(bit [2:0] stage, int len, bit [11:0] c[6]);
            seg_t r;
            if (err != ssm_pkg::ST_OK)
                return;
            if (count >= seg_limit)
            begin
                err = stage;
                return;
            end
            r.len = 11'(len);
            r.col = c;
            r.status = ssm_pkg::ST_OK;
            r.last = 0;
            pending.push_back(r);
            count++;
            made++;
        endfunction

        function void note_word(word_t w);
            bit [11:0] clip[6];
            int p, e, s, se, off, len;
            seg_t r;
            made = 0;
            if (w.kind == 0)
            begin
                sp_start = w.start;
                sp_len = w.len;
                sp_col = w.col;
                pos = 0;
                count = 0;
                err = ssm_pkg::ST_OK;
                ph = ssm_pkg::PH_BEFORE;
                return;
            end
            if (ph == ssm_pkg::PH_WAIT)
                return;
            len = w.len;
            p = pos;
            e = p + len - 1;
            s = sp_start;
            se = s + int'(sp_len) - 1;
            if (ph == ssm_pkg::PH_BEFORE)
            begin
                if (sp_len == 0 || e < s)
                    emit(ssm_pkg::ST_BEFORE, len, w.col);
                else
                begin
                    if (p < s)
                    begin
                        clip = w.col;
                        for (int i = 0; i < 3; i++)
                            clip[3+i] = interp(w.col[i], w.col[3+i], s - p, len);
                        emit(ssm_pkg::ST_CLIP_START, s - p, clip);
                    end
                    ph = ssm_pkg::PH_COVER;
                end
            end
            if (ph == ssm_pkg::PH_COVER)
            begin
                if (!(p <= se && e <= se))
                begin
                    emit(ssm_pkg::ST_INSERT, sp_len, sp_col);
                    if (p <= se)
                    begin
                        off = se + 1 - p;
                        clip = w.col;
                        for (int i = 0; i < 3; i++)
                            clip[i] = interp(w.col[i], w.col[3+i], off, len);
                        emit(ssm_pkg::ST_CLIP_END, len - off, clip);
                    end
                    else
                        emit(ssm_pkg::ST_AFTER, len, w.col);
                    ph = ssm_pkg::PH_AFTER;
                end
            end
            else if (ph == ssm_pkg::PH_AFTER)
                emit(ssm_pkg::ST_AFTER, len, w.col);
            pos = (pos + len > int'(ssm_pkg::POS_LIMIT)) ? int'(ssm_pkg::POS_LIMIT)
                                                         : pos + len;
            if (w.last)
            begin
                if (ph == ssm_pkg::PH_COVER || (ph == ssm_pkg::PH_BEFORE && sp_len != 0))
                    emit(ssm_pkg::ST_INSERT, sp_len, sp_col);
                if (err != ssm_pkg::ST_OK)
                begin
                    r.len = 0;
                    foreach (r.col[i]) r.col[i] = 0;
                    r.status = err;
                    r.last = 1;
                    pending.push_back(r);
                end
                else if (made > 0)
                    pending[$].last = 1;
                ph = ssm_pkg::PH_WAIT;
                pos = 0;
                count = 0;
                err = ssm_pkg::ST_OK;
            end
        endfunction

        function void field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(seg_t a);
            seg_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result word, length %0d status %0d", a.len, a.status);
                errors++;
                return;
            end
            x = pending.pop_front();
            field("out_length", x.len, a.len);
            field("out_red_begin", x.col[0], a.col[0]);
            field("out_green_begin", x.col[1], a.col[1]);
            field("out_blue_begin", x.col[2], a.col[2]);
            field("out_red_end", x.col[3], a.col[3]);
            field("out_green_end", x.col[4], a.col[4]);
            field("out_blue_end", x.col[5], a.col[5]);
            field("status", x.status, a.status);
            field("out_last", x.last, a.last);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic kind = 0;
    logic [ssm_pkg::START_W-1:0] start_req = 0;
    logic [ssm_pkg::LEN_W-1:0] length = 0;
    logic [ssm_pkg::COL_W-1:0] red_begin = 0, green_begin = 0, blue_begin = 0;
    logic [ssm_pkg::COL_W-1:0] red_end = 0, green_end = 0, blue_end = 0;
    logic list_end = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [ssm_pkg::CNT_W-1:0] max_out_segments = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [ssm_pkg::LEN_W-1:0] out_length;
    logic [ssm_pkg::COL_W-1:0] out_red_begin, out_green_begin, out_blue_begin;
    logic [ssm_pkg::COL_W-1:0] out_red_end, out_green_end, out_blue_end;
    logic [ssm_pkg::ERR_W-1:0] status;
    logic out_last;

    merge_scoreboard sb = new();
    bit calm = 0;
    bit hold = 0;
    int words_sent = 0;
    int quiet = 0;

    always #2 clk = ~clk;

    scanline_span_merge DUT (.*);

    task automatic send(word_t w);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        kind = w.kind;
        start_req = w.start;
        length = w.len;
        {red_begin, green_begin, blue_begin} = {w.col[0], w.col[1], w.col[2]};
        {red_end, green_end, blue_end} = {w.col[3], w.col[4], w.col[5]};
        list_end = w.last;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic word(bit k, int st, int ln, int cb, int ce, bit lst);
        word_t w;
        w.kind = k;
        w.start = 10'(st);
        w.len = 11'(ln);
        for (int i = 0; i < 3; i++)
        begin
            w.col[i] = 12'(cb);
            w.col[3+i] = 12'(ce);
        end
        w.last = lst;
        send(w);
    endtask

    task automatic rand_word(bit k, int ln, bit lst);
        word_t w;
        w.kind = k;
        w.start = 10'($urandom_range(1023));
        w.len = 11'(ln);
        foreach (w.col[i]) w.col[i] = 12'($urandom);
        w.last = lst;
        send(w);
    endtask

    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 15)
            return $urandom_range(1024);
        return $urandom_range(1, 300);
    endfunction

    task automatic scanline();
        int n;
        if ($urandom_range(99) < 5)
            rand_word(1, rand_len(), $urandom_range(1));
        rand_word(0, ($urandom_range(99) < 10) ? 0 : rand_len(), $urandom_range(1));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 4)
                rand_word(0, rand_len(), 0);
            rand_word(1, rand_len(), i == n - 1);
        end
    endtask

    task automatic settle_and_write(int v);
        @(negedge clk);
        in_valid = 0;
        wait (sb.pending.size() == 0);
        repeat (200) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1;
        max_out_segments = 7'(v);
        do @(posedge clk); while (!cfg_ready);
        sb.seg_limit = 7'(v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    always @(negedge clk)
        out_stall <= hold || (!calm && $urandom_range(99) < 17);

    always @(posedge clk)
    begin
        seg_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.len = out_length;
            r.col[0] = out_red_begin;
            r.col[1] = out_green_begin;
            r.col[2] = out_blue_begin;
            r.col[3] = out_red_end;
            r.col[4] = out_green_end;
            r.col[5] = out_blue_end;
            r.status = status;
            r.last = out_last;
            sb.check_result(r);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 6000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        wait (words_sent >= 60);
        hold = 1;
        repeat (700) @(posedge clk);
        hold = 0;
    end

    initial
    begin
        int limits[5] = '{32, 1, 64, 2, 0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        settle_and_write(32);
        word(1, 0, 40, 7, 9, 1);
        word(0, 100, 50, 4095, 0, 1);
        word(1, 0, 80, 0, 4095, 0);
        word(1, 0, 100, 4095, 0, 0);
        word(1, 0, 0, 1, 2, 0);
        word(1, 0, 1024, 4095, 4095, 1);
        word(0, 1023, 1024, 1234, 2345, 0);
        word(1, 0, 10, 0, 4095, 1);
        word(0, 5, 0, 11, 22, 0);
        word(1, 0, 7, 3, 4000, 0);
        word(1, 0, 1024, 4000, 3, 1);
        word(0, 0, 1024, 0, 4095, 0);
        word(1, 0, 1024, 4095, 0, 0);
        word(1, 0, 5, 100, 200, 1);
        word(0, 500, 3, 9, 9, 0);
        word(0, 0, 1, 4095, 4095, 0);
        word(1, 0, 1024, 0, 4095, 1);
        for (int ph = 0; ph < 5; ph++)
        begin
            calm = (ph == 2);
            if (ph > 0)
                settle_and_write(limits[ph] == 0 ? $urandom_range(3, 10) : limits[ph]);
            while (words_sent < 20 + 50 * (ph + 1))
                scanline();
        end
        calm = 0;
        @(negedge clk);
        in_valid = 0;
        wait (sb.pending.size() == 0);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/ssm_pkg.sv
sv/ssm_lerp.sv
sv/ssm_dp.sv
sv/ssm_ctrl.sv
sv/scanline_span_merge.sv
bench/tb.sv
